// File: rtl/core/vsd_pkg.sv
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and constants for the varint stream decoder.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int unsigned ValueWidth = 64;
    localparam int unsigned CountWidth = 4;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned CfgIdxWidth  = 1;
    localparam int unsigned CfgDataWidth = 1;

    localparam logic [CountWidth-1:0] MaxBytes64 = 4'd10;
    localparam logic [CountWidth-1:0] MaxBytes32 = 4'd5;
    localparam logic [6:0]            PayloadMask = 7'h7F;
    localparam int unsigned           ContBit = 7;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CfgWidthMode  = 1'b0;
    localparam logic [CfgIdxWidth-1:0] CfgZigzagMode = 1'b1;

    typedef struct packed {
        logic [ValueWidth-1:0] acc;
        logic [CountWidth-1:0] cnt;
        logic                  discarding;
    } dec_state_t;

    typedef struct packed {
        logic [ValueWidth-1:0] value;
        logic [CountWidth-1:0] byte_count;
        logic                  error;
        logic                  buffer_end;
    } dec_result_t;

    typedef struct packed {
        logic width_mode;
        logic zigzag_mode;
    } dec_cfg_t;

endpackage

// File: rtl/core/vsd_stream_if.sv
// ----------------------------------------------------------------------------
// vsd_byte_if / vsd_result_if
// Valid/ready channels for input bytes and decoded results.
// ----------------------------------------------------------------------------
interface vsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vsd_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [3:0]  byte_count;
    logic        error;
    logic        buffer_end;

    modport source (output valid, output value, output byte_count, output error,
                    output buffer_end, input ready);
    modport sink   (input valid, input value, input byte_count, input error,
                    input buffer_end, output ready);
endinterface

// File: rtl/core/vsd_step.sv
// ----------------------------------------------------------------------------
// vsd_step
// One-byte update of the decoder state and the result it produces.
// ----------------------------------------------------------------------------
module vsd_step (
    input  vsd_pkg::dec_state_t      state,
    input  vsd_pkg::dec_cfg_t        cfg,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    output vsd_pkg::dec_state_t      state_next,
    output vsd_pkg::dec_result_t     result,
    output logic                     has_result
);
    import vsd_pkg::*;

    logic [CountWidth-1:0] limit;
    logic [6:0]            shamt;
    logic [ValueWidth-1:0] acc_new;
    logic [CountWidth-1:0] cnt_new;
    logic [31:0]           n32;
    logic [31:0]           z32;
    logic [ValueWidth-1:0] fin;

    assign limit   = cfg.width_mode ? MaxBytes32 : MaxBytes64;
    // 7 * cnt; only used while cnt < limit, so it stays below 64
    assign shamt   = {state.cnt, 3'b000} - {3'b000, state.cnt};
    assign cnt_new = state.cnt + 4'd1;

    always_comb
    begin
        acc_new = state.acc
                | ({57'd0, data_byte[6:0] & PayloadMask} << shamt[5:0]);
        if (cfg.width_mode)
        begin
            acc_new[63:32] = '0;
        end
    end

    // zigzag and width finishing of a completed number
    always_comb
    begin
        n32 = acc_new[31:0];
        z32 = {1'b0, n32[31:1]} ^ {32{n32[0]}};
        unique case ({cfg.width_mode, cfg.zigzag_mode})
            2'b11:   fin = {{32{z32[31]}}, z32};
            2'b10:   fin = {32'd0, n32};
            2'b01:   fin = {1'b0, acc_new[63:1]} ^ {ValueWidth{acc_new[0]}};
            default: fin = acc_new;
        endcase
    end

    always_comb
    begin
        state_next = state;
        result     = '0;
        has_result = 1'b0;
        priority if (state.discarding)
        begin
            if (last_byte)
            begin
                state_next = '0;
            end
        end
        else if (state.cnt >= limit)
        begin
            state_next            = '0;
            state_next.discarding = ~last_byte;
            result.error          = 1'b1;
            result.buffer_end     = last_byte;
            has_result            = 1'b1;
        end
        else if (!data_byte[ContBit])
        begin
            state_next        = '0;
            result.value      = fin;
            result.byte_count = cnt_new;
            result.buffer_end = last_byte;
            has_result        = 1'b1;
        end
        else if (last_byte)
        begin
            state_next        = '0;
            result.error      = 1'b1;
            result.buffer_end = 1'b1;
            has_result        = 1'b1;
        end
        else
        begin
            state_next.acc = acc_new;
            state_next.cnt = cnt_new;
        end
    end

endmodule

// File: rtl/core/varint_stream_decoder.sv
// ----------------------------------------------------------------------------
// varint_stream_decoder
// Base-128 varint decoder over a byte stream, one byte per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   byte_ch   : input beats, one raw byte each; last_byte marks buffer end.
//   result_ch : output beats, at most one per input byte: value, byte_count,
//               error, buffer_end. Errors carry value 0 and byte_count 0.
//   cfg_we / cfg_index / cfg_data : register writes (0 width_mode,
//               1 zigzag_mode), only while the block is idle.
// Path: a byte passes the input register, then the result register (two
//   register stages), before it shows at the outputs.
// Throughput: one byte per cycle unless result_ch holds off a result; the
//   per-byte shift-or into the accumulator and zigzag finish are combinational.
// Reset: clears the number state, discard flag, modes and both valid flags.
// Stall: when result_ch is held off, the result register keeps its beat and
//   the input register still holds one more byte; bytes that give no result
//   pass through even while the result register is full.
// ----------------------------------------------------------------------------
module varint_stream_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vsd_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [vsd_pkg::CfgDataWidth-1:0]    cfg_data,
    vsd_byte_if.sink                            byte_ch,
    vsd_result_if.source                        result_ch
);
    import vsd_pkg::*;

    dec_cfg_t    cfg_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t step_result;
    logic        step_has_result;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // result register
    logic        out_valid_reg;
    dec_result_t out_reg;

    logic out_free;
    logic step_go;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgWidthMode:  cfg_reg.width_mode  <= cfg_data[0];
                CfgZigzagMode: cfg_reg.zigzag_mode <= cfg_data[0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    vsd_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .state_next (state_next),
        .result     (step_result),
        .has_result (step_has_result)
    );

    // The staged byte moves on when the result slot is free or when it makes
    // no result at all.
    assign out_free      = ~out_valid_reg | result_ch.ready;
    assign step_go       = in_valid_reg & (out_free | ~step_has_result);
    assign byte_ch.ready = ~in_valid_reg | step_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            in_valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            in_byte_reg <= byte_ch.data_byte;
            in_last_reg <= byte_ch.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_go && step_has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && step_has_result)
        begin
            out_reg <= step_result;
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.value      = out_reg.value;
    assign result_ch.byte_count = out_reg.byte_count;
    assign result_ch.error      = out_reg.error;
    assign result_ch.buffer_end = out_reg.buffer_end;

endmodule

// File: rtl/core/vsd_checker.sv
// ----------------------------------------------------------------------------
// vsd_checker
// Port-level checks on the varint stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module vsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_value,
    input logic [3:0]  out_count,
    input logic        out_error
);
    import vsd_pkg::*;

    // a held-off result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value)
                                    && $stable(out_count) && $stable(out_error))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_value == '0 && out_count == '0)
        else $error("error result with nonzero payload");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_error |-> out_count != '0 && out_count <= MaxBytes64)
        else $error("byte count out of range");

    // a fresh result comes from a byte accepted through the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching byte");

endmodule

bind varint_stream_decoder vsd_checker u_vsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_ch.valid),
    .in_ready  (byte_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_value (result_ch.value),
    .out_count (result_ch.byte_count),
    .out_error (result_ch.error)
);
